>>> src/mbe_pkg.sv
package mbe_pkg;

	// Fixed-point format of c and z
	localparam int FRAC_BITS   = 25;
	localparam int WORD_W      = 32;
	localparam int PROD_W      = 2 * WORD_W;
	// Iteration count and limit share one width
	localparam int COUNT_WIDTH = 16;
	localparam logic [COUNT_WIDTH-1:0] LIMIT_RESET = COUNT_WIDTH'(300);

	// Ring of stages: one slot per stage, slot count must be a power of two
	localparam int SLOTS = 4;
	localparam int SEQ_W = $clog2(SLOTS);

	// Escape bound |z|^2 >= 4 in the scaled domain
	localparam logic signed [PROD_W-1:0] ESCAPE_FX = PROD_W'(64'sd4 <<< FRAC_BITS);

	// Stream widths, rounded up to whole bytes
	localparam int IN_W  = 2 * WORD_W;
	localparam int OUT_W = ((COUNT_WIDTH + 2 + 7) / 8) * 8;

	typedef struct packed {
		logic                   done;
		logic [SEQ_W-1:0]       seq;
		logic [COUNT_WIDTH-1:0] count;
		logic signed [WORD_W-1:0] zr;
		logic signed [WORD_W-1:0] zi;
		logic signed [WORD_W-1:0] cr;
		logic signed [WORD_W-1:0] ci;
	} slot_t;

	typedef struct packed {
		slot_t                    slot;
		logic signed [WORD_W-1:0] sum;
		logic signed [WORD_W-1:0] dif;
	} front_t;

	typedef struct packed {
		slot_t                    slot;
		logic signed [PROD_W-1:0] p_rr;
		logic signed [PROD_W-1:0] p_ii;
		logic signed [PROD_W-1:0] p_sd;
		logic signed [PROD_W-1:0] p_ri;
	} prod_t;

	typedef struct packed {
		slot_t                    slot;
		logic signed [PROD_W-1:0] mag;
		logic signed [WORD_W-1:0] nr;
		logic signed [WORD_W-1:0] ni;
	} acc_t;

endpackage

>>> src/mbe_front.sv
module mbe_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  mbe_pkg::slot_t in_slot,
	output logic           valid_s2,
	output mbe_pkg::prod_t prod_s2
);
	import mbe_pkg::*;

	logic   valid_s1;
	front_t front_s1;

	function automatic logic signed [PROD_W-1:0] fx_prod(
		input logic signed [WORD_W-1:0] a,
		input logic signed [WORD_W-1:0] b
	);
		return a * b;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// Stage 1: wrapped sum and difference for the real-part square
	always_ff @(posedge clk) begin
		front_s1.slot <= in_slot;
		front_s1.sum  <= in_slot.zr + in_slot.zi;
		front_s1.dif  <= in_slot.zr - in_slot.zi;
	end

	// Stage 2: the four full-width products
	always_ff @(posedge clk) begin
		prod_s2.slot <= front_s1.slot;
		prod_s2.p_rr <= fx_prod(front_s1.slot.zr, front_s1.slot.zr);
		prod_s2.p_ii <= fx_prod(front_s1.slot.zi, front_s1.slot.zi);
		prod_s2.p_sd <= fx_prod(front_s1.sum, front_s1.dif);
		prod_s2.p_ri <= fx_prod(front_s1.slot.zr, front_s1.slot.zi);
	end

endmodule

>>> src/mbe_back.sv
module mbe_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [mbe_pkg::COUNT_WIDTH-1:0] limit,
	input  logic                            valid_s2,
	input  mbe_pkg::prod_t                  prod_s2,
	output logic                            valid_s4,
	output mbe_pkg::slot_t                  slot_s4
);
	import mbe_pkg::*;

	logic                     valid_s3;
	acc_t                     acc_s3;
	logic signed [PROD_W-1:0] rr_sh, ii_sh, sd_sh, ri_sh;
	logic                     escape;
	logic [COUNT_WIDTH-1:0]   count_n;
	slot_t                    next_slot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// Stage 3: rescale products, form |z|^2 and the next z
	always_comb begin
		rr_sh = prod_s2.p_rr >>> FRAC_BITS;
		ii_sh = prod_s2.p_ii >>> FRAC_BITS;
		sd_sh = prod_s2.p_sd >>> FRAC_BITS;
		ri_sh = prod_s2.p_ri >>> FRAC_BITS;
	end

	always_ff @(posedge clk) begin
		acc_s3.slot <= prod_s2.slot;
		acc_s3.mag  <= rr_sh + ii_sh;
		acc_s3.nr   <= $signed(sd_sh[WORD_W-1:0] + prod_s2.slot.cr);
		acc_s3.ni   <= $signed({ri_sh[WORD_W-2:0], 1'b0} + prod_s2.slot.ci);
	end

	// Stage 4: escape test, count step, limit check; finished slots hold
	always_comb begin
		escape    = (acc_s3.mag >= ESCAPE_FX);
		count_n   = acc_s3.slot.count + COUNT_WIDTH'(1);
		next_slot = acc_s3.slot;
		if (!acc_s3.slot.done) begin
			if (escape) begin
				next_slot.done = 1'b1;
			end else begin
				next_slot.count = count_n;
				if (count_n >= limit) begin
					next_slot.done = 1'b1;
				end else begin
					next_slot.zr = acc_s3.nr;
					next_slot.zi = acc_s3.ni;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		slot_s4 <= next_slot;
	end

endmodule

>>> src/mandelbrot_escape_iteration_core.sv
// Mandelbrot escape-time core. Each input item is a point c (c_real in tdata
// bits 31:0, c_imag in bits 63:32, signed, 25 fraction bits); each output item
// carries the iteration count, a flag for reaching iteration_limit, and the
// pixel bit (escaped with a count above one). One iteration of z = z*z + c runs
// through a four-stage ring (sum/difference, products, rescale/add, escape and
// limit decision). A point makes count passes when it reaches the limit and
// count+1 passes when it escapes (the failing escape test is one more pass);
// m_tvalid rises once the finished point, back out of stage 4, is taken into
// the output register, provided that register is free.
// The ring holds up to four points at once, one per stage, and a new point
// enters whenever the slot coming back around is empty, so the sustained rate
// depends on the counts of neighboring points and, in the worst case, on the
// limit (300 after reset). Results leave strictly in input order: a finished
// point keeps circulating until all older points have left. iteration_limit is
// written through limit_we/limit_wdata; the user must write it only while no
// point is in flight, as the core itself does not enforce this.
module mandelbrot_escape_iteration_core (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration: iteration_limit
	input  logic                            limit_we,
	input  logic [mbe_pkg::COUNT_WIDTH-1:0] limit_wdata,
	// input items
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [mbe_pkg::IN_W-1:0]        s_tdata,   // c_real, c_imag
	// result items
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [mbe_pkg::OUT_W-1:0]       m_tdata    // iteration_count, hit_limit, pixel_on
);
	import mbe_pkg::*;

	logic [COUNT_WIDTH-1:0] limit_q;
	logic [SEQ_W-1:0]       in_seq_q;
	logic [SEQ_W-1:0]       ret_seq_q;
	logic                   out_valid_q;
	logic [COUNT_WIDTH-1:0] out_count_q;
	logic                   out_hit_q;
	logic                   out_pix_q;

	logic   valid_s2, valid_s4;
	prod_t  prod_s2;
	slot_t  slot_s4;
	logic   entry_valid;
	slot_t  entry_slot;
	logic   in_take;
	logic   retire;

	// Admit a point only into the empty slot that returns to stage 1
	assign s_tready = !valid_s4;
	assign in_take  = s_tvalid && s_tready;

	// Drop the oldest finished point into the output register when it is free
	assign retire = valid_s4 && slot_s4.done && (slot_s4.seq == ret_seq_q)
		&& (!out_valid_q || m_tready);

	always_comb begin
		entry_valid = (valid_s4 && !retire) || in_take;
		entry_slot  = slot_s4;
		if (!valid_s4) begin
			entry_slot.done  = 1'b0;
			entry_slot.seq   = in_seq_q;
			entry_slot.count = '0;
			entry_slot.zr    = '0;
			entry_slot.zi    = '0;
			entry_slot.cr    = $signed(s_tdata[WORD_W-1:0]);
			entry_slot.ci    = $signed(s_tdata[2*WORD_W-1:WORD_W]);
		end
	end

	mbe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (entry_valid),
		.in_slot  (entry_slot),
		.valid_s2 (valid_s2),
		.prod_s2  (prod_s2)
	);

	mbe_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.limit    (limit_q),
		.valid_s2 (valid_s2),
		.prod_s2  (prod_s2),
		.valid_s4 (valid_s4),
		.slot_s4  (slot_s4)
	);

	// Control: limit register, order tags, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= LIMIT_RESET;
			in_seq_q    <= '0;
			ret_seq_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (limit_we) begin
				limit_q <= limit_wdata;
			end
			if (in_take) begin
				in_seq_q <= in_seq_q + SEQ_W'(1);
			end
			if (retire) begin
				ret_seq_q   <= ret_seq_q + SEQ_W'(1);
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload: classify the final count against the limit
	always_ff @(posedge clk) begin
		if (retire) begin
			out_count_q <= slot_s4.count;
			out_hit_q   <= (slot_s4.count == limit_q);
			out_pix_q   <= (slot_s4.count != limit_q) && (slot_s4.count > COUNT_WIDTH'(1));
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'({out_pix_q, out_hit_q, out_count_q});

	// A point still iterating has counted at least one pass
	a_live_count: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 && !slot_s4.done |-> slot_s4.count != '0)
		else $error("live slot with zero count");

	// Every result has counted the first pass
	a_out_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_count_q != '0)
		else $error("result with zero count");

	// The limit flag and the pixel bit exclude each other
	a_out_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_hit_q && out_pix_q))
		else $error("hit_limit and pixel_on both set");

	// A retired slot leaves the ring empty for the next admission
	a_retire_free: assert property (@(posedge clk) disable iff (!arst_n)
		retire && !in_take |=> ##3 !valid_s4)
		else $error("retired slot came back valid");

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import mbe_pkg::*;

	// Run ends here with an error report, counted from the start of the run
	localparam int CYCLE_LIMIT = 4_000_000;
	// Hold the result side this long once, so the ring fills and input stalls
	localparam int LONG_HOLD   = 600;

	// Handy fixed-point values, 25 fraction bits
	localparam logic signed [WORD_W-1:0] FX_ONE  = 32'sd33554432;
	localparam logic signed [WORD_W-1:0] FX_TWO  = 32'sd67108864;
	localparam logic signed [WORD_W-1:0] FX_MAX  = 32'sh7fffffff;
	localparam logic signed [WORD_W-1:0] FX_MIN  = 32'sh80000000;

	// One expected result: field order follows m_tdata from the bottom up
	typedef struct packed {
		logic [COUNT_WIDTH-1:0] count;
		logic                   hit;
		logic                   pixel;
	} escape_t;

	logic                   clk         = 1'b0;
	logic                   arst_n      = 1'b0;
	logic                   limit_we    = 1'b0;
	logic [COUNT_WIDTH-1:0] limit_wdata = '0;
	logic                   s_tvalid    = 1'b0;
	logic                   s_tready;
	logic [IN_W-1:0]        s_tdata     = '0;   // c_real, c_imag
	logic                   m_tvalid;
	logic                   m_tready    = 1'b0;
	logic [OUT_W-1:0]       m_tdata;            // iteration_count, hit_limit, pixel_on

	// Points waiting to be offered, packed {c_imag, c_real}
	logic [IN_W-1:0]        point_q[$];
	// Escape results predicted for accepted points, oldest first
	escape_t                escape_due[$];
	// Limit the core holds right now, tracked on every write
	logic [COUNT_WIDTH-1:0] limit_shadow = LIMIT_RESET;

	int points_queued = 0;
	int points_in     = 0;
	int results_seen  = 0;
	int err_count     = 0;
	int send_gap      = 0;
	int send_calm     = 0;
	int recv_gap      = 0;
	int recv_calm     = 0;
	int recv_hold     = 0;
	int hold_at       = -1;
	bit hold_done     = 1'b0;
	int cycles        = 0;

	mandelbrot_escape_iteration_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.limit_we    (limit_we),
		.limit_wdata (limit_wdata),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Hold reset low at the start, then release it away from the rising edge
	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// Product of two wrapped 32-bit values, formed exactly and rescaled
	function automatic longint scaled_product(longint a, longint b);
		return (a * b) >>> FRAC_BITS;
	endfunction

	// Iterate z = z*z + c from zero until escape or the limit; parts of z wrap to 32 bits
	function automatic escape_t predict_escape(logic signed [WORD_W-1:0] cr,
			logic signed [WORD_W-1:0] ci, logic [COUNT_WIDTH-1:0] lim);
		logic signed [WORD_W-1:0] zr, zi, zsum, zdif, nr, ni;
		int unsigned              n;
		escape_t                  res;
		zr = '0;
		zi = '0;
		n  = 0;
		// the |z|^2 test runs on the full 64-bit sum, no truncation
		while (scaled_product(zr, zr) + scaled_product(zi, zi) < ESCAPE_FX) begin
			n++;
			if (n >= lim)
				break;
			zsum = zr + zi;
			zdif = zr - zi;
			nr   = WORD_W'(scaled_product(zsum, zdif)) + cr;
			// double the cross term modulo 2^32 before adding c_imag
			ni   = WORD_W'(scaled_product(zr, zi) << 1) + ci;
			zr   = nr;
			zi   = ni;
		end
		res.count = n[COUNT_WIDTH-1:0];
		res.hit   = (n == lim);
		res.pixel = !res.hit && (n > 1);
		return res;
	endfunction

	// Wait before the next item: mostly a uniform random gap, with calm stretches of no waiting
	function automatic int draw_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 7) == 0)
			calm = $urandom_range(8, 40);
		return $urandom_range(0, 14);
	endfunction

	// Driver: offer queued points, predict each one as it is accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				escape_due.push_back(predict_escape(s_tdata[31:0], s_tdata[63:32], limit_shadow));
				points_in <= points_in + 1;
			end
			// advance only when nothing is on offer or the offer was just taken
			if (!s_tvalid || s_tready) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					s_tvalid <= 1'b0;
				end else if (point_q.size() != 0) begin
					s_tdata  <= point_q.pop_front();
					s_tvalid <= 1'b1;
					send_gap <= draw_wait(send_calm);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Long hold-off on the result side, armed once by the stimulus
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recv_hold <= 0;
		end else if (!hold_done && hold_at >= 0 && points_in >= hold_at) begin
			recv_hold <= LONG_HOLD;
			hold_done <= 1'b1;
		end else if (recv_hold != 0) begin
			recv_hold <= recv_hold - 1;
		end
	end

	// Monitor: compare each result item with the oldest prediction, then stall at random
	always @(posedge clk or negedge arst_n) begin : result_check
		escape_t got, want;
		int      gap_n;
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_gap <= 0;
		end else begin
			gap_n = recv_gap;
			if (m_tvalid && m_tready) begin
				got.count = m_tdata[COUNT_WIDTH-1:0];
				got.hit   = m_tdata[COUNT_WIDTH];
				got.pixel = m_tdata[COUNT_WIDTH+1];
				results_seen++;
				if (escape_due.size() == 0) begin
					if (err_count < 10)
						$display("%0t: result with no point pending: count %0d hit %0b pixel %0b",
							$time, got.count, got.hit, got.pixel);
					err_count++;
				end else begin
					want = escape_due.pop_front();
					if (got.count !== want.count || got.hit !== want.hit ||
							got.pixel !== want.pixel) begin
						if (err_count < 10)
							$display("%0t: result %0d expected count %0d hit %0b pixel %0b, got count %0d hit %0b pixel %0b",
								$time, results_seen, want.count, want.hit, want.pixel,
								got.count, got.hit, got.pixel);
						err_count++;
					end
				end
				gap_n = draw_wait(recv_calm);
			end else if (gap_n != 0) begin
				gap_n--;
			end
			recv_gap <= gap_n;
			m_tready <= (gap_n == 0) && (recv_hold == 0);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	// Block until every queued point has come back as a result
	task automatic settle();
		do @(negedge clk); while (results_seen < points_queued);
	endtask

	// Write iteration_limit with the core empty
	task automatic write_limit(input logic [COUNT_WIDTH-1:0] v);
		settle();
		@(posedge clk);
		limit_we    <= 1'b1;
		limit_wdata <= v;
		@(posedge clk);
		limit_we     <= 1'b0;
		limit_shadow  = v;
		@(negedge clk);
	endtask

	task automatic queue_point(input logic signed [WORD_W-1:0] re, input logic signed [WORD_W-1:0] im);
		point_q.push_back({im, re});
		points_queued++;
	endtask

	// Random points: some fully random words, most near the set where counts get long
	task automatic queue_random(input int n);
		logic signed [WORD_W-1:0] re, im;
		repeat (n) begin
			case ($urandom_range(0, 9))
				0, 1: begin
					re = $urandom;
					im = $urandom;
				end
				2, 3: begin
					// around the main body, mostly inside: [-0.5, 0.25] x [-0.5, 0.5]
					re = $urandom_range(0, 25165824) - 32'd16777216;
					im = $urandom_range(0, 33554432) - 32'd16777216;
				end
				default: begin
					// whole picture: [-2.25, 0.75] x [-1.5, 1.5]
					re = $urandom_range(0, 100663296) - 32'd75497472;
					im = $urandom_range(0, 100663296) - 32'd50331648;
				end
			endcase
			queue_point(re, im);
		end
	endtask

	initial begin : stimulus
		wait (arst_n === 1'b1);
		@(negedge clk);

		// Directed points at the reset limit
		queue_point(32'sd0, 32'sd0);                 // origin, stays inside
		queue_point(FX_MAX, FX_MAX);                 // extremes escape at once
		queue_point(FX_MIN, FX_MIN);
		queue_point(FX_MAX, FX_MIN);
		queue_point(FX_MIN, FX_MAX);
		queue_point(-FX_TWO, 32'sd0);                // |z|^2 lands exactly on 4
		queue_point(FX_TWO, 32'sd0);
		queue_point(32'sd8388608, 32'sd0);           // cusp at 0.25, inside
		queue_point(32'sd8724152, 32'sd0);           // just past the cusp, slow escape
		queue_point(-32'sd25165824, 32'sd3355443);   // neck near -0.75
		queue_point(32'sd0, FX_ONE);                 // i, period-two orbit
		queue_point(32'sd0, -FX_ONE);
		queue_point(-FX_ONE, 32'sd0);
		queue_point(FX_ONE, 32'sd0);
		queue_point(-32'sd1, -32'sd1);               // smallest negative step
		queue_point(32'sd1, 32'sd0);
		queue_point(32'sh55555555, 32'shaaaaaaaa);
		queue_point(32'shaaaaaaaa, 32'sh55555555);

		// Zero limit: the count check fails on the first pass
		write_limit(16'd0);
		queue_point(32'sd0, 32'sd0);
		queue_point(-FX_ONE, 32'sd0);
		queue_point(FX_MAX, FX_MIN);
		queue_random(3);

		// Limit of one: every point reports hitting the limit
		write_limit(16'd1);
		queue_point(32'sd0, 32'sd0);
		queue_point(-FX_ONE, 32'sd0);
		queue_point(FX_MIN, FX_MAX);
		queue_random(3);

		// Largest limit: one inside point takes the full count
		write_limit(16'hffff);
		queue_point(32'sd0, 32'sd0);
		queue_point(32'sd10066329, 32'sd0);          // 0.3, escapes with a count of 12
		queue_point(FX_MAX, FX_MIN);

		// Random phases over several limits
		write_limit(16'd2);
		queue_random(150);

		write_limit(16'd37);
		hold_at = points_queued + 60;
		queue_random(200);

		write_limit(16'd128);
		queue_random(200);

		write_limit(16'd300);
		queue_random(200);

		// Drain, then give stray results time to show up
		settle();
		repeat (4 * 300 + 50) @(posedge clk);
		if (escape_due.size() != 0)
			err_count += escape_due.size();

		if (err_count == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
